FILE: design/rqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue scheduler package
// Shared widths, command codes and cell control types for the cell chain.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int CMD_W = 2;
    localparam int ID_W  = 8;
    localparam int CNT_OUT_W = 5;

    // Command codes carried on the request channel.
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TERM  = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_LOAD = 2'd1;
    localparam cell_op_t CELL_POP  = 2'd2;
    localparam cell_op_t CELL_ROT  = 2'd3;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   head_id;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/rqs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue request channel
// Valid/ready channel carrying one command and one thread id per transfer.
// ----------------------------------------------------------------------------
interface rqs_req_if
    import rqs_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   thread_id;

    modport source (output valid, output command, output thread_id, input ready);
    modport sink   (input valid, input command, input thread_id, output ready);

endinterface

`default_nettype wire

FILE: design/rqs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue response channel
// Valid/ready channel carrying the result of one command per transfer.
// ----------------------------------------------------------------------------
interface rqs_rsp_if
    import rqs_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic                  dispatch_valid;
    logic [ID_W-1:0]       dispatch_id;
    logic                  removed;
    logic                  overflow;
    logic [CNT_OUT_W-1:0]  ready_count;

    modport source (output valid, output dispatch_valid, output dispatch_id,
                    output removed, output overflow, output ready_count,
                    input ready);
    modport sink   (input valid, input dispatch_valid, input dispatch_id,
                    input removed, input overflow, input ready_count,
                    output ready);

endinterface

`default_nettype wire

FILE: design/rqs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds the thread id at one queue position. Cell 0 is the head. On a pop
// or rotate every cell takes its right neighbor's id; on a rotate the cell
// at the tail takes the old head instead. On a load the cell at the first
// free position takes the new id.
// ----------------------------------------------------------------------------
module rqs_cell
    import rqs_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
) (
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [ID_W-1:0]   nbr_id,
    output logic      [ID_W-1:0]   id
);

    localparam logic [CNT_W-1:0] POS      = CNT_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(CELL_INDEX + 1);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    // Select the next id from the broadcast operation and this cell's position.
    always_comb
    begin
        id_next = id_reg;
        unique case (ctrl.op)
            CELL_HOLD: id_next = id_reg;
            CELL_LOAD:
            begin
                if (count == POS)
                begin
                    id_next = ctrl.new_id;
                end
            end
            CELL_POP:  id_next = nbr_id;
            CELL_ROT:
            begin
                if (count == POS_NEXT)
                begin
                    id_next = ctrl.head_id;
                end
                else
                begin
                    id_next = nbr_id;
                end
            end
            default:   id_next = id_reg;
        endcase
    end

    // Payload storage; entries beyond the fill count never reach the response.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

FILE: design/ready_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue scheduler
// FIFO ready queue of thread ids held in a chain of cells, head in cell 0.
//
//   channel   dir   payload                                           role
//   req       in    command, thread_id                                command
//   rsp       out   dispatch_valid, dispatch_id, removed, overflow,   result
//                   ready_count
//
// One command is worked at a time. Add and yield pass from the idle state
// to the busy state, which registers the result. Terminate rotates the
// chain one position per cycle until the id is at the head or a full turn
// is made; the walk over the cells sets the worst case. A result waits in
// the output register while the next command is taken; work that would
// produce a second result stalls until the first one is transferred. Reset
// empties the queue; cell contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ready_queue_scheduler
    import rqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rqs_req_if.sink    req,
    rqs_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic              state_reg,  state_next;
    logic [CMD_W-1:0]  cmd_reg,    cmd_next;
    logic [ID_W-1:0]   tid_reg,    tid_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  walk_reg,   walk_next;
    logic              out_valid_reg, out_valid_next;
    logic              dv_reg,     dv_next;
    logic [ID_W-1:0]   did_reg,    did_next;
    logic              rem_reg,    rem_next;
    logic              ovf_reg,    ovf_next;

    logic              slot_free;
    logic              finish;
    cell_ctrl_t        ctrl;
    logic [ID_W-1:0]   cell_id [QUEUE_DEPTH];

    // Chain of cells; the last cell's neighbor input is a constant zero filler.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] nbr;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_id[i+1];
        end

        rqs_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .count  (count_reg),
            .nbr_id (nbr),
            .id     (cell_id[i])
        );
    end

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Command sequencer: one step per cycle, finishing only when slot_free.
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        tid_next    = tid_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        dv_next     = dv_reg;
        did_next    = did_reg;
        rem_next    = rem_reg;
        ovf_next    = ovf_reg;
        finish      = 1'b0;
        ctrl.op      = CELL_HOLD;
        ctrl.new_id  = tid_reg;
        ctrl.head_id = cell_id[0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    tid_next   = req.thread_id;
                    walk_next  = '0;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (slot_free)
                        begin
                            finish   = 1'b1;
                            dv_next  = 1'b0;
                            did_next = '0;
                            rem_next = 1'b0;
                            if (count_reg == FULL_COUNT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ovf_next   = 1'b0;
                                ctrl.op    = CELL_LOAD;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                    end
                    CMD_YIELD:
                    begin
                        if (slot_free)
                        begin
                            finish   = 1'b1;
                            rem_next = 1'b0;
                            ovf_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                dv_next    = 1'b1;
                                did_next   = cell_id[0];
                                ctrl.op    = CELL_POP;
                                count_next = count_reg - CNT_ONE;
                            end
                            else
                            begin
                                dv_next  = 1'b0;
                                did_next = '0;
                            end
                        end
                    end
                    CMD_TERM:
                    begin
                        // A full turn without a match restores the order.
                        priority if (walk_reg == count_reg)
                        begin
                            if (slot_free)
                            begin
                                finish   = 1'b1;
                                dv_next  = 1'b0;
                                did_next = '0;
                                rem_next = 1'b0;
                                ovf_next = 1'b0;
                            end
                        end
                        else if (cell_id[0] == tid_reg)
                        begin
                            if (slot_free)
                            begin
                                finish     = 1'b1;
                                dv_next    = 1'b0;
                                did_next   = '0;
                                rem_next   = 1'b1;
                                ovf_next   = 1'b0;
                                ctrl.op    = CELL_POP;
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        else
                        begin
                            ctrl.op   = CELL_ROT;
                            walk_next = walk_reg + CNT_ONE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            finish   = 1'b1;
                            dv_next  = 1'b0;
                            did_next = '0;
                            rem_next = 1'b0;
                            ovf_next = 1'b0;
                        end
                    end
                endcase

                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register holds a result until its transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        tid_reg <= tid_next;
        dv_reg  <= dv_next;
        did_reg <= did_next;
        rem_reg <= rem_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.dispatch_valid = dv_reg;
    assign rsp.dispatch_id    = did_reg;
    assign rsp.removed        = rem_reg;
    assign rsp.overflow       = ovf_reg;

    // The count register always holds the count after the last result.
    if (CNT_W >= CNT_OUT_W)
    begin : g_cnt_trunc
        assign rsp.ready_count = count_reg[CNT_OUT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign rsp.ready_count = {{(CNT_OUT_W-CNT_W){1'b0}}, count_reg};
    end

endmodule

`default_nettype wire
